FILE: sv/tbcc_pkg.sv
// Shared types, codes and sizes of the track buffer cache controller.
package tbcc_pkg;

  localparam int NUM_TRACKS        = 16;
  // The offset of a sector within its track is taken from the low address bits.
  localparam int SECTORS_PER_TRACK = 8;
  localparam int SLOT_W            = $clog2(NUM_TRACKS);
  localparam int OFF_W             = (SECTORS_PER_TRACK > 1) ? $clog2(SECTORS_PER_TRACK) : 1;
  localparam logic [SECTORS_PER_TRACK-1:0] ALL_SECT = '1;

  typedef enum logic [2:0] {
    FN_GET_RD  = 3'd0,
    FN_GET_WR  = 3'd1,
    FN_RELEASE = 3'd2,
    FN_PURGE   = 3'd3,
    FN_SYNC    = 3'd4
  } tbcc_func_t;

  typedef enum logic [2:0] {
    K_GRANT    = 3'd0,
    K_READ     = 3'd1,
    K_WRITE    = 3'd2,
    K_RELEASED = 3'd3,
    K_NO_FREE  = 3'd4,
    K_BUSY     = 3'd5,
    K_DONE     = 3'd6
  } tbcc_kind_t;

  typedef enum logic [2:0] {
    CM_NONE,
    CM_INSTALL,
    CM_FRONT,
    CM_CLR_STALE,
    CM_CLR_MODIMM,
    CM_GRANT,
    CM_REL,
    CM_TRIM
  } tbcc_op_t;

  // Command broadcast along the row of cells.
  typedef struct packed {
    tbcc_op_t                    op;
    logic [SLOT_W-1:0]           sel;
    logic [7:0]                  fs;
    logic [31:0]                 addr;
    logic [SECTORS_PER_TRACK-1:0] bitm;
    logic [SLOT_W-1:0]           rank;
    logic                        mod;
    logic                        imm;
  } tbcc_cmd_t;

  // State one cell shows to the sequencer.
  typedef struct packed {
    logic                        valid;
    logic [7:0]                  fs;
    logic [31:0]                 addr;
    logic                        m_stale;
    logic                        m_mod;
    logic                        m_imm;
    logic [SECTORS_PER_TRACK-1:0] present;
    logic [SECTORS_PER_TRACK-1:0] held;
    logic [SECTORS_PER_TRACK-1:0] sstale;
    logic [SLOT_W-1:0]           rank;
  } tbcc_track_t;

endpackage

FILE: sv/tbcc_cell.sv
// One track buffer cell: tag, marks, sector masks and LRU rank of one slot.
module tbcc_cell import tbcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] idx,
  input  tbcc_cmd_t         cmd,
  output tbcc_track_t       st
);

  tbcc_track_t st_r, st_nxt;
  logic        sel;

  assign sel = (cmd.sel == idx);
  assign st  = st_r;

  always_comb begin
    st_nxt = st_r;
    case (cmd.op)
      CM_INSTALL: if (sel) begin
        st_nxt.valid   = 1'b1;
        st_nxt.fs      = cmd.fs;
        st_nxt.addr    = cmd.addr;
        st_nxt.m_stale = 1'b1;
        st_nxt.m_mod   = 1'b0;
        st_nxt.m_imm   = 1'b0;
        st_nxt.present = '0;
        st_nxt.held    = '0;
        st_nxt.sstale  = '0;
      end
      CM_FRONT: begin
        if (sel) st_nxt.rank = SLOT_W'(NUM_TRACKS - 1);
        else if (st_r.rank > cmd.rank) st_nxt.rank = st_r.rank - 1'b1;
      end
      CM_CLR_STALE:  if (sel) st_nxt.m_stale = 1'b0;
      CM_CLR_MODIMM: if (sel) begin
        st_nxt.m_mod = 1'b0;
        st_nxt.m_imm = 1'b0;
      end
      CM_GRANT: if (sel) begin
        if ((st_r.present & cmd.bitm) == '0) begin
          st_nxt.present = st_r.present | cmd.bitm;
          st_nxt.sstale  = st_r.m_stale ? (st_r.sstale | cmd.bitm) : (st_r.sstale & ~cmd.bitm);
        end
        st_nxt.held = st_r.held | cmd.bitm;
      end
      CM_REL: if (sel) begin
        if ((st_r.sstale & cmd.bitm) != '0) st_nxt.m_stale = 1'b1;
        if (cmd.mod) st_nxt.m_mod = 1'b1;
        if (cmd.imm) st_nxt.m_imm = 1'b1;
        st_nxt.sstale = st_r.sstale & ~cmd.bitm;
        st_nxt.held   = st_r.held & ~cmd.bitm;
      end
      CM_TRIM: if (sel) begin
        st_nxt.m_stale = 1'b1;
        st_nxt.m_mod   = 1'b0;
        st_nxt.m_imm   = 1'b0;
        st_nxt.present = st_r.present & st_r.held;
        st_nxt.sstale  = st_r.sstale & st_r.held;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid   <= 1'b0;
      st_r.m_stale <= 1'b0;
      st_r.m_mod   <= 1'b0;
      st_r.m_imm   <= 1'b0;
      st_r.present <= '0;
      st_r.held    <= '0;
      st_r.sstale  <= '0;
      st_r.rank    <= idx;
      st_r.fs      <= st_nxt.fs;
      st_r.addr    <= st_nxt.addr;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: sv/track_buffer_cache_controller_core.sv
// Top level of the track buffer cache controller: sequencer, row of track cells, result register.
//
// Usage:
//   in_*  : one request beat per handshake (get read, get overwrite, release, purge, sync).
//   out_* : one or more result beats per request; out_tlast marks the final one.
//   Results are grant, read track, write track, released, no free track, sector busy, done.
// Request flow:
//   A request is taken only while the sequencer is idle; it works on one request at a time.
//   A get walks all NUM_TRACKS cells one slot a cycle to find a hit and the oldest free
//   slot; a miss installs the victim after any write-back, and a read may add a fill read.
//   An ignored release is answered from its check step; otherwise the track is updated and
//   may be written back. Purge and sync visit every slot in turn, writing back modified tracks.
// Reset:
//   All tracks go invalid with no held sectors, LRU ranks ascend from slot zero (oldest).
// Stall:
//   A result beat sits in the output register until out_tready; the sequencer holds in
//   the emitting step meanwhile and resumes when the register frees up.
module track_buffer_cache_controller_core import tbcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: fs_id[7:0], sector_addr[39:8], slot[43:40], sector_offset[46:44],
  //        modified[47], write_now[48], zero fill[55:49]
  input  logic [55:0] in_tdata,
  // tuser: func[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: slot_res[3:0], sector_offset_res[6:4], fs_id_res[14:7], track_addr[46:15],
  //        fill_mask[54:47], stale[55]
  output logic [55:0] out_tdata,
  // tuser: kind[2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_SCAN     = 17'h00002,
    S_DECIDE   = 17'h00004,
    S_GCHK     = 17'h00008,
    S_VCHK     = 17'h00010,
    S_WB_CHK   = 17'h00020,
    S_WB_READ  = 17'h00040,
    S_WB_WRITE = 17'h00080,
    S_INSTALL  = 17'h00100,
    S_FRONT    = 17'h00200,
    S_GRD      = 17'h00400,
    S_GBITS    = 17'h00800,
    S_GRANT    = 17'h01000,
    S_REL_CHK  = 17'h02000,
    S_REL_IMM  = 17'h04000,
    S_REL_OUT  = 17'h08000,
    S_PG       = 17'h10000
  } state_t;

  // Done beats reuse the idle-return path through a dedicated flag.
  state_t            state_r, state_nxt;
  logic              done_pend_r, done_pend_nxt;

  // Latched request
  logic [2:0]        func_r;
  logic [7:0]        fs_r;
  logic [31:0]       addr_r;
  logic [3:0]        slot_r;
  logic [2:0]        off_r;
  logic              mod_r, wn_r;

  // Walk results
  logic [SLOT_W-1:0] sl_r, sl_nxt;
  logic              hit_f_r, hit_f_nxt, vic_f_r, vic_f_nxt;
  logic [SLOT_W-1:0] hit_sl_r, hit_sl_nxt, vic_sl_r, vic_sl_nxt, vic_rank_r, vic_rank_nxt;

  // Output register
  logic              ov_r;
  logic [2:0]        ok_r;
  logic [3:0]        os_r;
  logic [2:0]        oo_r;
  logic [7:0]        of_r;
  logic [31:0]       oa_r;
  logic [7:0]        om_r;
  logic              ost_r, ol_r;

  tbcc_cmd_t         cmd;
  tbcc_track_t       cells_st [NUM_TRACKS];
  tbcc_track_t       cur;

  logic              in_acc, out_free, ld;
  logic [2:0]        e_kind, e_off;
  logic [7:0]        e_fs, e_fill;
  logic [31:0]       e_addr;
  logic [3:0]        e_slot;
  logic              e_stale, e_last;
  logic [OFF_W-1:0]  toff;
  logic [31:0]       taddr;
  logic [SECTORS_PER_TRACK-1:0] gbit, rbit, fill;
  logic              last_slot, is_get, rel_ok;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_TRACKS; gi++) begin : g_cell
      tbcc_cell u_cell (
        .clk (clk),
        .rst_n (rst_n),
        .idx (SLOT_W'(gi)),
        .cmd (cmd),
        .st  (cells_st[gi])
      );
    end
  endgenerate

  assign cur       = cells_st[sl_r];
  assign in_tready = (state_r == S_IDLE) && !done_pend_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !ov_r || out_tready;
  assign toff      = addr_r[OFF_W-1:0];
  assign taddr     = {addr_r[31:OFF_W], {OFF_W{1'b0}}};
  assign gbit      = SECTORS_PER_TRACK'(1) << toff;
  assign rbit      = SECTORS_PER_TRACK'(1) << off_r;
  assign fill      = (cur.present == '0) ? ALL_SECT : (ALL_SECT & ~cur.present);
  assign last_slot = (sl_r == SLOT_W'(NUM_TRACKS - 1));
  assign is_get    = (func_r == FN_GET_RD) || (func_r == FN_GET_WR);
  assign rel_ok    = (int'(slot_r) < NUM_TRACKS) && (int'(off_r) < SECTORS_PER_TRACK);

  always_comb begin
    state_nxt     = state_r;
    done_pend_nxt = done_pend_r;
    sl_nxt        = sl_r;
    hit_f_nxt     = hit_f_r;
    hit_sl_nxt    = hit_sl_r;
    vic_f_nxt     = vic_f_r;
    vic_sl_nxt    = vic_sl_r;
    vic_rank_nxt  = vic_rank_r;
    cmd.op        = CM_NONE;
    cmd.sel       = sl_r;
    cmd.fs        = fs_r;
    cmd.addr      = taddr;
    cmd.bitm      = gbit;
    cmd.rank      = cur.rank;
    cmd.mod       = mod_r;
    cmd.imm       = wn_r;
    ld            = 1'b0;
    e_kind        = K_DONE;
    e_slot        = 4'(sl_r);
    e_off         = 3'd0;
    e_fs          = cur.fs;
    e_addr        = cur.addr;
    e_fill        = 8'd0;
    e_stale       = 1'b0;
    e_last        = 1'b0;

    if (done_pend_r) begin
      // Final done beat of purge, sync or an unknown code
      if (out_free) begin
        ld = 1'b1; e_kind = K_DONE; e_slot = 4'd0; e_fs = 8'd0; e_addr = 32'd0;
        e_last = 1'b1; done_pend_nxt = 1'b0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          sl_nxt    = '0;
          hit_f_nxt = 1'b0;
          vic_f_nxt = 1'b0;
          case (in_tuser) inside
            FN_GET_RD, FN_GET_WR: state_nxt = S_SCAN;
            FN_RELEASE:           state_nxt = S_REL_CHK;
            FN_PURGE, FN_SYNC:    state_nxt = S_PG;
            default:              done_pend_nxt = 1'b1;
          endcase
        end
        S_SCAN: begin
          if (cur.valid && cur.fs == fs_r && cur.addr == taddr && !hit_f_r) begin
            hit_f_nxt = 1'b1; hit_sl_nxt = sl_r;
          end
          if (cur.held == '0 && (!vic_f_r || cur.rank < vic_rank_r)) begin
            vic_f_nxt = 1'b1; vic_sl_nxt = sl_r; vic_rank_nxt = cur.rank;
          end
          if (last_slot) state_nxt = S_DECIDE;
          else sl_nxt = sl_r + 1'b1;
        end
        S_DECIDE: begin
          if (hit_f_r) begin
            sl_nxt = hit_sl_r; state_nxt = S_GCHK;
          end else if (vic_f_r) begin
            sl_nxt = vic_sl_r; state_nxt = S_VCHK;
          end else if (out_free) begin
            ld = 1'b1; e_kind = K_NO_FREE; e_slot = 4'd0; e_off = 3'(toff);
            e_fs = fs_r; e_addr = taddr; e_last = 1'b1; state_nxt = S_IDLE;
          end
        end
        S_GCHK: begin
          if ((cur.held & gbit) != '0) begin
            if (out_free) begin
              ld = 1'b1; e_kind = K_BUSY; e_off = 3'(toff); e_fs = fs_r;
              e_addr = taddr; e_last = 1'b1; state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_FRONT;
          end
        end
        S_VCHK: state_nxt = (cur.valid && cur.m_mod) ? S_WB_CHK : S_INSTALL;
        S_WB_CHK: begin
          if (cur.m_stale && cur.present != ALL_SECT) begin
            state_nxt = S_WB_READ;
          end else begin
            if (cur.m_stale) cmd.op = CM_CLR_STALE;
            state_nxt = S_WB_WRITE;
          end
        end
        S_WB_READ: if (out_free) begin
          ld = 1'b1; e_kind = K_READ; e_fill = 8'(fill);
          cmd.op = CM_CLR_STALE; state_nxt = S_WB_WRITE;
        end
        S_WB_WRITE: if (out_free) begin
          ld = 1'b1; e_kind = K_WRITE;
          if (is_get) begin
            state_nxt = S_INSTALL;
          end else if (func_r == FN_RELEASE) begin
            cmd.op = CM_CLR_MODIMM; state_nxt = S_REL_OUT;
          end else begin
            cmd.op = (func_r == FN_PURGE) ? CM_TRIM : CM_CLR_MODIMM;
            if (last_slot) begin
              done_pend_nxt = 1'b1; state_nxt = S_IDLE;
            end else begin
              sl_nxt = sl_r + 1'b1; state_nxt = S_PG;
            end
          end
        end
        S_INSTALL: begin
          cmd.op = CM_INSTALL; state_nxt = S_FRONT;
        end
        S_FRONT: begin
          cmd.op = CM_FRONT; state_nxt = S_GRD;
        end
        S_GRD: begin
          if (func_r == FN_GET_RD && cur.m_stale) begin
            if (out_free) begin
              ld = 1'b1; e_kind = K_READ; e_fill = 8'(fill);
              cmd.op = CM_CLR_STALE; state_nxt = S_GBITS;
            end
          end else begin
            state_nxt = S_GBITS;
          end
        end
        S_GBITS: begin
          cmd.op = CM_GRANT; state_nxt = S_GRANT;
        end
        S_GRANT: if (out_free) begin
          ld = 1'b1; e_kind = K_GRANT; e_off = 3'(toff);
          e_stale = ((cur.sstale & gbit) != '0); e_last = 1'b1; state_nxt = S_IDLE;
        end
        S_REL_CHK: begin
          sl_nxt = SLOT_W'(slot_r);
          if (rel_ok && cells_st[SLOT_W'(slot_r)].valid &&
              (cells_st[SLOT_W'(slot_r)].held & rbit) != '0) begin
            cmd.op = CM_REL; cmd.sel = SLOT_W'(slot_r); cmd.bitm = rbit;
            state_nxt = S_REL_IMM;
          end else if (out_free) begin
            // Ignored release: answer with zero tag fields
            ld = 1'b1; e_kind = K_RELEASED; e_slot = slot_r; e_off = off_r;
            e_fs = 8'd0; e_addr = 32'd0; e_last = 1'b1; state_nxt = S_IDLE;
          end
        end
        S_REL_IMM: begin
          if (cur.m_imm && cur.m_mod) begin
            state_nxt = S_WB_CHK;
          end else begin
            if (cur.m_imm) cmd.op = CM_CLR_MODIMM;
            state_nxt = S_REL_OUT;
          end
        end
        S_REL_OUT: if (out_free) begin
          ld = 1'b1; e_kind = K_RELEASED; e_off = off_r; e_last = 1'b1;
          state_nxt = S_IDLE;
        end
        S_PG: begin
          if (func_r == FN_PURGE && cur.valid && cur.fs == fs_r) begin
            if (cur.m_mod) state_nxt = S_WB_CHK;
            else cmd.op = CM_TRIM;
          end else if (func_r == FN_SYNC && cur.valid && cur.m_mod) begin
            state_nxt = S_WB_CHK;
          end
          if (!(cur.valid && cur.m_mod &&
                (func_r == FN_SYNC || cur.fs == fs_r))) begin
            if (last_slot) begin
              done_pend_nxt = 1'b1; state_nxt = S_IDLE;
            end else begin
              sl_nxt = sl_r + 1'b1;
            end
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      done_pend_r <= 1'b0;
      ov_r        <= 1'b0;
      sl_r        <= '0;
      hit_f_r     <= 1'b0;
      vic_f_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_pend_r <= done_pend_nxt;
      sl_r        <= sl_nxt;
      hit_f_r     <= hit_f_nxt;
      vic_f_r     <= vic_f_nxt;
      if (out_free) ov_r <= ld;
    end
  end

  always_ff @(posedge clk) begin
    hit_sl_r   <= hit_sl_nxt;
    vic_sl_r   <= vic_sl_nxt;
    vic_rank_r <= vic_rank_nxt;
    if (in_acc) begin
      func_r <= in_tuser;
      fs_r   <= in_tdata[7:0];
      addr_r <= in_tdata[39:8];
      slot_r <= in_tdata[43:40];
      off_r  <= in_tdata[46:44];
      mod_r  <= in_tdata[47];
      wn_r   <= in_tdata[48];
    end
    if (ld) begin
      ok_r  <= e_kind;
      os_r  <= e_slot;
      oo_r  <= e_off;
      of_r  <= e_fs;
      oa_r  <= e_addr;
      om_r  <= e_fill;
      ost_r <= e_stale;
      ol_r  <= e_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ok_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {ost_r, om_r, oa_r, of_r, oo_r, os_r};

  // Only read-track beats carry a fill mask
  a_fill_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ok_r != K_READ |-> om_r == 8'd0)
    else $error("fill mask on non-read beat");

  // Grant, busy and no-free beats always end their request
  a_final_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (ok_r == K_GRANT || ok_r == K_BUSY || ok_r == K_NO_FREE) |-> ol_r)
    else $error("terminal kind without last");

  // An accepted request moves the sequencer out of idle or queues a done beat
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE) || done_pend_r)
    else $error("request accepted without work");

  // No new request is taken while a done beat is pending
  a_no_take_pending: assert property (@(posedge clk) disable iff (!rst_n)
    done_pend_r |-> !in_tready)
    else $error("ready while done pending");

endmodule

FILE: verif/tb.sv
// Self-checking bench for the track buffer cache controller core.
module tb;
  import tbcc_pkg::*;

  localparam logic [2:0] FN_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] FN_UNKNOWN_HI = 3'd7;
  localparam logic [2:0] MK_STALE = 3'b001;
  localparam logic [2:0] MK_MOD   = 3'b010;
  localparam logic [2:0] MK_IMM   = 3'b100;
  localparam int N_RANDOM   = 390;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLDOFF    = 300;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [55:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  track_buffer_cache_controller_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  typedef struct {
    tbcc_kind_t  kind;
    logic [3:0]  slot;
    logic [2:0]  off;
    logic [7:0]  fs;
    logic [31:0] taddr;
    logic [7:0]  fill;
    logic        stale;
    logic        last;
  } cache_result_t;

  cache_result_t result_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 0;

  // Shadow copy of the track table.
  bit          trk_valid[NUM_TRACKS];
  logic [7:0]  trk_fs[NUM_TRACKS];
  logic [31:0] trk_addr[NUM_TRACKS];
  logic [2:0]  trk_marks[NUM_TRACKS];
  logic [7:0]  trk_present[NUM_TRACKS];
  logic [7:0]  trk_held[NUM_TRACKS];
  logic [7:0]  trk_sstale[NUM_TRACKS];
  logic [3:0]  trk_rank[NUM_TRACKS];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic push_result(tbcc_kind_t k, int s, logic [2:0] off, logic [7:0] fs,
                             logic [31:0] ta, logic [7:0] fill, logic stl);
    cache_result_t r;
    r.kind = k; r.slot = s[3:0]; r.off = off; r.fs = fs; r.taddr = ta;
    r.fill = fill; r.stale = stl; r.last = 0;
    result_q.push_back(r);
  endtask

  task automatic fill_read(int s);
    logic [7:0] fill;
    fill = (trk_present[s] == 0) ? ALL_SECT : (ALL_SECT & ~trk_present[s]);
    push_result(K_READ, s, 0, trk_fs[s], trk_addr[s], fill, 0);
    trk_marks[s] &= ~MK_STALE;
  endtask

  // Complete a stale track before writing it back.
  task automatic write_back(int s);
    if (trk_marks[s] & MK_STALE) begin
      if (trk_present[s] != ALL_SECT) fill_read(s);
      else trk_marks[s] &= ~MK_STALE;
    end
    push_result(K_WRITE, s, 0, trk_fs[s], trk_addr[s], 0, 0);
  endtask

  task automatic move_to_front(int s);
    logic [3:0] r;
    r = trk_rank[s];
    for (int i = 0; i < NUM_TRACKS; i++) if (trk_rank[i] > r) trk_rank[i]--;
    trk_rank[s] = 4'(NUM_TRACKS - 1);
  endtask

  task automatic predict_get(logic [7:0] fs, logic [31:0] addr, bit rd);
    logic [2:0]  toff;
    logic [31:0] ta;
    logic [7:0]  bitm;
    int s;
    toff = addr[2:0];
    ta = {addr[31:3], 3'b000};
    bitm = 8'd1 << toff;
    s = -1;
    for (int i = 0; i < NUM_TRACKS; i++)
      if (s < 0 && trk_valid[i] && trk_fs[i] == fs && trk_addr[i] == ta) s = i;
    if (s >= 0) begin
      if (trk_held[s] & bitm) begin
        push_result(K_BUSY, s, toff, fs, ta, 0, 0);
        return;
      end
    end else begin
      for (int i = 0; i < NUM_TRACKS; i++)
        if (trk_held[i] == 0 && (s < 0 || trk_rank[i] < trk_rank[s])) s = i;
      if (s < 0) begin
        push_result(K_NO_FREE, 0, toff, fs, ta, 0, 0);
        return;
      end
      if (trk_valid[s] && (trk_marks[s] & MK_MOD)) write_back(s);
      trk_valid[s] = 1; trk_fs[s] = fs; trk_addr[s] = ta;
      trk_marks[s] = MK_STALE;
      trk_present[s] = 0; trk_held[s] = 0; trk_sstale[s] = 0;
    end
    move_to_front(s);
    if (rd && (trk_marks[s] & MK_STALE)) fill_read(s);
    if (!(trk_present[s] & bitm)) begin
      trk_present[s] |= bitm;
      if (trk_marks[s] & MK_STALE) trk_sstale[s] |= bitm;
      else trk_sstale[s] &= ~bitm;
    end
    trk_held[s] |= bitm;
    push_result(K_GRANT, s, toff, fs, ta, 0, (trk_sstale[s] & bitm) != 0);
  endtask

  task automatic predict_release(int s, logic [2:0] off, bit md, bit wn);
    logic [7:0] bitm;
    bitm = 8'd1 << off;
    if (!trk_valid[s] || !(trk_held[s] & bitm)) begin
      push_result(K_RELEASED, s, off, 0, 0, 0, 0);
      return;
    end
    if (trk_sstale[s] & bitm) trk_marks[s] |= MK_STALE;
    if (md) trk_marks[s] |= MK_MOD;
    if (wn) trk_marks[s] |= MK_IMM;
    trk_sstale[s] &= ~bitm;
    trk_held[s] &= ~bitm;
    if (trk_marks[s] & MK_IMM) begin
      if (trk_marks[s] & MK_MOD) write_back(s);
      trk_marks[s] &= ~(MK_MOD | MK_IMM);
    end
    push_result(K_RELEASED, s, off, trk_fs[s], trk_addr[s], 0, 0);
  endtask

  // Work out every result one request causes and queue them in order.
  task automatic predict_request(logic [2:0] fn, logic [7:0] fs, logic [31:0] addr,
                                 logic [3:0] slot, logic [2:0] off, bit md, bit wn);
    case (fn)
      FN_GET_RD:  predict_get(fs, addr, 1);
      FN_GET_WR:  predict_get(fs, addr, 0);
      FN_RELEASE: predict_release(slot, off, md, wn);
      FN_PURGE: begin
        for (int s = 0; s < NUM_TRACKS; s++) begin
          if (trk_valid[s] && trk_fs[s] == fs) begin
            if (trk_marks[s] & MK_MOD) write_back(s);
            trk_marks[s] = MK_STALE;
            trk_present[s] &= trk_held[s];
            trk_sstale[s] &= trk_held[s];
          end
        end
        push_result(K_DONE, 0, 0, 0, 0, 0, 0);
      end
      FN_SYNC: begin
        for (int s = 0; s < NUM_TRACKS; s++) begin
          if (trk_valid[s] && (trk_marks[s] & MK_MOD)) begin
            write_back(s);
            trk_marks[s] &= ~(MK_MOD | MK_IMM);
          end
        end
        push_result(K_DONE, 0, 0, 0, 0, 0, 0);
      end
      default: push_result(K_DONE, 0, 0, 0, 0, 0, 0);
    endcase
    result_q[result_q.size()-1].last = 1;
  endtask

  // Offer one request, hold it until accepted, then predict its results.
  task automatic send_request(logic [2:0] fn, logic [7:0] fs, logic [31:0] addr,
                              logic [3:0] slot, logic [2:0] off, bit md, bit wn);
    int gap;
    in_tvalid <= 1;
    in_tuser  <= fn;
    in_tdata  <= {7'd0, wn, md, off, slot, addr, fs};
    do @(posedge clk); while (!in_tready);
    predict_request(fn, fs, addr, slot, off, md, wn);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(3, 1);
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, or a long hold-off counted here.
  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_recv) begin
        out_tready <= 0;
        repeat (HOLDOFF - 1) @(posedge clk);
        hold_recv = 0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result beat kind=%0d data=%h last=%b",
                 $time, out_tuser, out_tdata, out_tlast);
        errors++;
      end else begin
        cache_result_t e;
        e = result_q.pop_front();
        if (out_tuser !== e.kind || out_tdata[3:0] !== e.slot || out_tdata[6:4] !== e.off ||
            out_tdata[14:7] !== e.fs || out_tdata[46:15] !== e.taddr ||
            out_tdata[54:47] !== e.fill || out_tdata[55] !== e.stale ||
            out_tlast !== e.last) begin
          $display("%0t: mismatch expected kind=%0d slot=%0d off=%0d fs=%h ta=%h fill=%h stale=%b last=%b",
                   $time, e.kind, e.slot, e.off, e.fs, e.taddr, e.fill, e.stale, e.last);
          $display("%0t:          actual kind=%0d slot=%0d off=%0d fs=%h ta=%h fill=%h stale=%b last=%b",
                   $time, out_tuser, out_tdata[3:0], out_tdata[6:4], out_tdata[14:7],
                   out_tdata[46:15], out_tdata[54:47], out_tdata[55], out_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run after too long without any beat moving.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // A row with has_exp carries its single result kind typed in.
  typedef struct {
    logic [2:0]  fn;
    logic [7:0]  fs;
    logic [31:0] addr;
    logic [3:0]  slot;
    logic [2:0]  off;
    bit          md, wn;
    bit          has_exp;
    tbcc_kind_t  exp_kind;
  } request_row_t;

  request_row_t plan[] = '{
    '{FN_UNKNOWN_LO, 8'h00, 32'h0, 4'd0, 3'd0, 0, 0, 1, K_DONE},
    '{FN_UNKNOWN_HI, 8'hFF, 32'hFFFFFFFF, 4'd15, 3'd7, 1, 1, 1, K_DONE},
    '{FN_RELEASE, 8'h00, 32'h0, 4'd0, 3'd0, 0, 0, 1, K_RELEASED},
    '{FN_SYNC,    8'h00, 32'h0, 4'd0, 3'd0, 0, 0, 1, K_DONE},
    '{FN_GET_RD,  8'h00, 32'h0, 4'd0, 3'd0, 0, 0, 0, K_GRANT},
    '{FN_GET_RD,  8'h00, 32'h0, 4'd0, 3'd0, 0, 0, 1, K_BUSY},
    '{FN_GET_WR,  8'hFF, 32'hFFFFFFFF, 4'd0, 3'd0, 0, 0, 0, K_GRANT},
    '{FN_RELEASE, 8'h00, 32'h0, 4'd1, 3'd7, 1, 1, 1, K_RELEASED},
    '{FN_GET_WR,  8'h00, 32'h3, 4'd0, 3'd0, 0, 0, 0, K_GRANT},
    '{FN_RELEASE, 8'h00, 32'h0, 4'd0, 3'd3, 1, 0, 0, K_GRANT},
    '{FN_RELEASE, 8'h00, 32'h0, 4'd0, 3'd0, 0, 0, 0, K_GRANT},
    '{FN_SYNC,    8'h00, 32'h0, 4'd0, 3'd0, 0, 0, 0, K_GRANT},
    '{FN_GET_WR,  8'h05, 32'h100, 4'd0, 3'd0, 0, 0, 0, K_GRANT},
    '{FN_RELEASE, 8'h00, 32'h0, 4'd2, 3'd0, 1, 0, 0, K_GRANT},
    '{FN_PURGE,   8'h05, 32'h0, 4'd0, 3'd0, 0, 0, 0, K_GRANT},
    '{FN_RELEASE, 8'h00, 32'h0, 4'd15, 3'd7, 1, 1, 1, K_RELEASED},
    '{FN_RELEASE, 8'h00, 32'h0, 4'd0, 3'd5, 0, 0, 1, K_RELEASED},
    '{FN_GET_RD,  8'h00, 32'h8, 4'd0, 3'd0, 0, 0, 0, K_GRANT},
    '{FN_PURGE,   8'h00, 32'h0, 4'd0, 3'd0, 0, 0, 0, K_GRANT},
    '{FN_GET_RD,  8'h00, 32'hA, 4'd0, 3'd0, 0, 0, 0, K_GRANT}
  };

  logic [7:0]  pool_fs[8];
  logic [31:0] pool_base[8];

  initial begin
    int n, pick, hs, ho;
    bit found;
    bit hold_done, drain_done;
    rst_n = 0;
    hold_done = 0;
    drain_done = 0;
    in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    for (int i = 0; i < NUM_TRACKS; i++) begin
      trk_valid[i] = 0; trk_fs[i] = 0; trk_addr[i] = 0; trk_marks[i] = 0;
      trk_present[i] = 0; trk_held[i] = 0; trk_sstale[i] = 0; trk_rank[i] = 4'(i);
    end
    for (int i = 0; i < 8; i++) begin
      pool_fs[i] = (i % 3 == 2) ? 8'hFF : 8'(i % 3);
      pool_base[i] = 32'({$urandom(), 3'b000}) ^ 32'(i << 3);
    end
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: rows with a typed kind replace the predicted one.
    foreach (plan[i]) begin
      send_request(plan[i].fn, plan[i].fs, plan[i].addr, plan[i].slot,
                   plan[i].off, plan[i].md, plan[i].wn);
      if (plan[i].has_exp) result_q[result_q.size()-1].kind = plan[i].exp_kind;
    end

    n = 0;
    while (n < N_RANDOM) begin
      case ((n / 100) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (n >= 150 && !hold_done) begin
        hold_done = 1;
        hold_recv = 1;
      end
      // Drain everything once, with the sender paused.
      if (n >= 260 && !drain_done) begin
        drain_done = 1;
        in_tvalid <= 0;
        while (result_q.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        int p;
        p = $urandom_range(7);
        send_request($urandom_range(1) ? FN_GET_RD : FN_GET_WR, pool_fs[p],
                     pool_base[p] + $urandom_range(7), 4'd0, 3'd0, 0, 0);
        n++;
      end else if (pick < 48) begin
        send_request($urandom_range(1) ? FN_GET_RD : FN_GET_WR, 8'($urandom_range(255)),
                     $urandom(), 4'($urandom_range(15)), 3'($urandom_range(7)), 0, 0);
        n++;
      end else if (pick < 80) begin
        // Release a sector that is really held, if one of 32 random picks finds one.
        found = 0;
        for (int t = 0; t < 32 && !found; t++) begin
          hs = $urandom_range(NUM_TRACKS - 1);
          ho = $urandom_range(7);
          found = trk_valid[hs] && trk_held[hs][ho];
        end
        send_request(FN_RELEASE, 8'($urandom_range(255)), $urandom(), 4'(hs), 3'(ho),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
        n++;
      end else if (pick < 85) begin
        send_request(FN_RELEASE, 8'($urandom_range(255)), $urandom(),
                     4'($urandom_range(15)), 3'($urandom_range(7)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
        n++;
      end else if (pick < 90) begin
        send_request(FN_PURGE, pool_fs[$urandom_range(7)], $urandom(), 4'd0, 3'd0, 0, 0);
        n++;
      end else if (pick < 95) begin
        send_request(FN_SYNC, 8'($urandom_range(255)), $urandom(), 4'd0, 3'd0, 0, 0);
        n++;
      end else if (pick < 97) begin
        send_request(3'($urandom_range(FN_UNKNOWN_HI, FN_UNKNOWN_LO)),
                     8'($urandom_range(255)), $urandom(), 4'($urandom_range(15)),
                     3'($urandom_range(7)), 0, 0);
        n++;
      end else begin
        // Pin every track with a held sector so the next new track finds none free.
        for (int j = 0; j <= NUM_TRACKS; j++) begin
          send_request(FN_GET_WR, 8'hA5, 32'({$urandom(), 3'b000}) + $urandom_range(7),
                       4'd0, 3'd0, 0, 0);
          n++;
        end
      end
    end
    in_tvalid <= 0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
